/* sv/koct_pkg.sv */
// ----------------------------------------------------------------------------
// koct_pkg
// Shared types and codes of the keyed occurrence count table: request and
// result codes, field widths and the result record.
// ----------------------------------------------------------------------------
package koct_pkg;

  localparam int CMD_W  = 2;
  localparam int CH_W   = 14;
  localparam int KEY_W  = 64;
  localparam int IDX_W  = 8;
  localparam int ST_W   = 3;
  localparam int CNT_W  = 32;
  localparam int USED_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_COUNTED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_BAD_INDEX = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [CH_W-1:0]   entry_channel;
    logic [KEY_W-1:0]  entry_key;
    logic [CNT_W-1:0]  entry_count;
    logic [USED_W-1:0] entries_used;
  } res_t;

endpackage

/* sv/koct_in_if.sv */
// ----------------------------------------------------------------------------
// koct_in_if
// Request channel of the count table: valid/ready plus the request fields.
// ----------------------------------------------------------------------------
interface koct_in_if;
  logic                        valid;
  logic                        ready;
  logic [koct_pkg::CMD_W-1:0]  cmd;
  logic [koct_pkg::CH_W-1:0]   channel;
  logic [koct_pkg::KEY_W-1:0]  cell_key;
  logic [koct_pkg::IDX_W-1:0]  read_index;

  modport source (output valid, cmd, channel, cell_key, read_index, input ready);
  modport sink   (input valid, cmd, channel, cell_key, read_index, output ready);
endinterface

/* sv/koct_out_if.sv */
// ----------------------------------------------------------------------------
// koct_out_if
// Result channel of the count table: valid/ready plus the result fields.
// ----------------------------------------------------------------------------
interface koct_out_if;
  logic                         valid;
  logic                         ready;
  logic [koct_pkg::ST_W-1:0]    status;
  logic [koct_pkg::CH_W-1:0]    entry_channel;
  logic [koct_pkg::KEY_W-1:0]   entry_key;
  logic [koct_pkg::CNT_W-1:0]   entry_count;
  logic [koct_pkg::USED_W-1:0]  entries_used;

  modport source (output valid, status, entry_channel, entry_key, entry_count,
                  entries_used, input ready);
  modport sink   (input valid, status, entry_channel, entry_key, entry_count,
                  entries_used, output ready);
endinterface

/* sv/keyed_occurrence_count_table_top.sv */
// ----------------------------------------------------------------------------
// keyed_occurrence_count_table_top
// Table of distinct (channel, cell id) keys with a saturating count each.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request: add a key (cmd 0), read the entry at
//   read_index (cmd 1) or clear the table (cmd 2); cmd 3 is taken and dropped.
//   out_ch returns one result per add, read or clear: status, the entry touched or read,
//   its count and the fill level after the request.
//   One request is worked on at a time; in_ch.ready is low while it runs.
//   An add scans the filled entries one per cycle through the single read
//   port of the table RAM; a read fetches its entry through the same port,
//   and a clear needs no RAM access.
//   Results pass through an output register; the next request is taken while
//   a result still waits there, and a request that finishes while the
//   receiver stalls holds its result until the register frees.
//   Reset empties the table at once by zeroing the fill level; no clearing
//   pass is needed, as entries beyond the fill level are never read.
// ----------------------------------------------------------------------------
module keyed_occurrence_count_table_top #(
  parameter int ENTRIES    = 256,
  parameter int COUNT_BITS = 32,
  parameter int KEY_BITS   = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  koct_in_if.sink       in_ch,
  koct_out_if.source    out_ch
);

  localparam int AW = $clog2(ENTRIES);
  localparam int W  = koct_pkg::CH_W + KEY_BITS + COUNT_BITS;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [W-1:0]   ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [W-1:0]   ram_rdata;
  logic           res_valid;
  logic           res_ready;
  koct_pkg::res_t res;

  logic           out_valid_r, out_valid_nxt;
  koct_pkg::res_t out_r, out_nxt;

  koct_ctrl #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .KEY_BITS   (KEY_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  koct_ram #(
    .WIDTH (W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.entry_channel = out_r.entry_channel;
  assign out_ch.entry_key     = out_r.entry_key;
  assign out_ch.entry_count   = out_r.entry_count;
  assign out_ch.entries_used  = out_r.entries_used;

  a_insert_count_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == koct_pkg::ST_INSERTED |->
      out_ch.entry_count == 32'd1 && out_ch.entries_used != 9'd0)
    else $error("inserted entry does not report a count of one");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == koct_pkg::ST_CLEARED |->
      out_ch.entries_used == 9'd0 && out_ch.entry_count == 32'd0)
    else $error("clear result carries a non-zero field");

  a_bad_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == koct_pkg::ST_BAD_INDEX |->
      out_ch.entry_key == 64'd0 && out_ch.entry_channel == 14'd0)
    else $error("out-of-range read returns entry data");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> !in_ch.ready)
    else $error("request taken while a result is still pending");

endmodule

/* sv/koct_ram.sv */
// ----------------------------------------------------------------------------
// koct_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module koct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/koct_ctrl.sv */
// ----------------------------------------------------------------------------
// koct_ctrl
// Sequencer of the count table: linear key search through the table RAM
// with one shared key comparator, count update, append, read and clear.
// ----------------------------------------------------------------------------
module koct_ctrl #(
  parameter int ENTRIES    = 256,
  parameter int COUNT_BITS = 32,
  parameter int KEY_BITS   = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  koct_in_if.sink                      in_ch,
  output logic                         ram_we,
  output logic [$clog2(ENTRIES)-1:0]   ram_waddr,
  output logic [koct_pkg::CH_W+KEY_BITS+COUNT_BITS-1:0] ram_wdata,
  output logic                         ram_re,
  output logic [$clog2(ENTRIES)-1:0]   ram_raddr,
  input  logic [koct_pkg::CH_W+KEY_BITS+COUNT_BITS-1:0] ram_rdata,
  output logic                         res_valid,
  input  logic                         res_ready,
  output koct_pkg::res_t               res
);

  localparam int AW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int CH = koct_pkg::CH_W;
  localparam int W  = CH + KEY_BITS + COUNT_BITS;
  localparam logic [FW-1:0]         FILL_MAX = FW'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_UPDATE = 5'b00100,
    S_RDWAIT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CH-1:0]         ch_r, ch_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [FW-1:0]         scan_r, scan_nxt;
  logic [FW-1:0]         fill_r, fill_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]         cmp_addr_r, cmp_addr_nxt;
  logic [AW-1:0]         hit_addr_r, hit_addr_nxt;
  logic [COUNT_BITS-1:0] hit_cnt_r, hit_cnt_nxt;
  koct_pkg::res_t        res_r, res_nxt;

  logic [CH-1:0]         rd_ch;
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  key_hit;
  logic                  scan_more;

  assign rd_cnt    = ram_rdata[COUNT_BITS-1:0];
  assign rd_key    = ram_rdata[COUNT_BITS +: KEY_BITS];
  assign rd_ch     = ram_rdata[W-1 -: CH];
  assign key_hit   = (rd_ch == ch_r) && (rd_key == key_r);
  assign scan_more = (scan_r < fill_r);
  assign new_cnt   = (hit_cnt_r == CNT_MAX) ? hit_cnt_r : hit_cnt_r + COUNT_BITS'(1);

  assign in_ch.ready = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_DONE);
  assign res         = res_r;

  always_comb begin
    state_nxt    = state_r;
    ch_nxt       = ch_r;
    key_nxt      = key_r;
    scan_nxt     = scan_r;
    fill_nxt     = fill_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_addr_nxt = cmp_addr_r;
    hit_addr_nxt = hit_addr_r;
    hit_cnt_nxt  = hit_cnt_r;
    res_nxt      = res_r;
    ram_we       = 1'b0;
    ram_waddr    = fill_r[AW-1:0];
    ram_wdata    = {ch_r, key_r, COUNT_BITS'(1)};
    ram_re       = 1'b0;
    ram_raddr    = scan_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.cmd)
            koct_pkg::CMD_ADD: begin
              ch_nxt      = in_ch.channel;
              key_nxt     = KEY_BITS'(in_ch.cell_key);
              scan_nxt    = '0;
              cmp_vld_nxt = 1'b0;
              state_nxt   = S_SEARCH;
            end
            koct_pkg::CMD_READ: begin
              if (32'(in_ch.read_index) < 32'(fill_r)) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_ch.read_index);
                state_nxt = S_RDWAIT;
              end else begin
                res_nxt   = '{koct_pkg::ST_BAD_INDEX, '0, '0, '0, 9'(fill_r)};
                state_nxt = S_DONE;
              end
            end
            koct_pkg::CMD_CLEAR: begin
              fill_nxt  = '0;
              res_nxt   = '{koct_pkg::ST_CLEARED, '0, '0, '0, '0};
              state_nxt = S_DONE;
            end
            default: ;  // unused code: drop the request
          endcase
        end
      end

      S_SEARCH: begin
        if (cmp_vld_r && key_hit) begin
          hit_addr_nxt = cmp_addr_r;
          hit_cnt_nxt  = rd_cnt;
          state_nxt    = S_UPDATE;
        end else if (!cmp_vld_r && !scan_more) begin
          // whole table scanned without a match: append or report full
          if (fill_r == FILL_MAX) begin
            res_nxt = '{koct_pkg::ST_FULL, ch_r, 64'(key_r), '0, 9'(fill_r)};
          end else begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
            res_nxt  = '{koct_pkg::ST_INSERTED, ch_r, 64'(key_r), 32'd1,
                         9'(fill_r + FW'(1))};
          end
          state_nxt = S_DONE;
        end else begin
          // issue the next read while comparing the previous one
          ram_re       = scan_more;
          cmp_vld_nxt  = scan_more;
          cmp_addr_nxt = scan_r[AW-1:0];
          if (scan_more) begin
            scan_nxt = scan_r + FW'(1);
          end
        end
      end

      S_UPDATE: begin
        ram_we    = 1'b1;
        ram_waddr = hit_addr_r;
        ram_wdata = {ch_r, key_r, new_cnt};
        res_nxt   = '{koct_pkg::ST_COUNTED, ch_r, 64'(key_r), 32'(new_cnt), 9'(fill_r)};
        state_nxt = S_DONE;
      end

      S_RDWAIT: begin
        res_nxt   = '{koct_pkg::ST_READ_OK, rd_ch, 64'(rd_key), 32'(rd_cnt), 9'(fill_r)};
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    key_r      <= key_nxt;
    scan_r     <= scan_nxt;
    cmp_addr_r <= cmp_addr_nxt;
    hit_addr_r <= hit_addr_nxt;
    hit_cnt_r  <= hit_cnt_nxt;
    res_r      <= res_nxt;
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed occurrence count table. A short table of
// hand-picked requests runs first, then random add/read/clear traffic over a
// small pool of recurring keys, with one run that fills the table to
// overflow. Every result is checked field by field against a local model of the
// table or a planned value, and both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = 256;
  localparam int RANDOM_ITEMS  = 700;
  localparam int POOL_SIZE     = 8;
  localparam int HOLD_CYCLES   = 600;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam logic [koct_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [koct_pkg::CMD_W-1:0] cmd;
    logic [koct_pkg::CH_W-1:0]  ch;
    logic [koct_pkg::KEY_W-1:0] key;
    logic [koct_pkg::IDX_W-1:0] idx;
    bit                         known;
    koct_pkg::res_t             res;
  } request_t;

  logic clk;
  logic rst_n;

  koct_in_if  in_ch();
  koct_out_if out_ch();

  keyed_occurrence_count_table_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the table
  logic [koct_pkg::CH_W-1:0]  tbl_channel [TABLE_ENTRIES];
  logic [koct_pkg::KEY_W-1:0] tbl_key     [TABLE_ENTRIES];
  logic [koct_pkg::CNT_W-1:0] tbl_count   [TABLE_ENTRIES];
  int                         tbl_fill;

  // recurring keys, so that adds hit existing entries
  logic [koct_pkg::CH_W-1:0]  pool_channel [POOL_SIZE];
  logic [koct_pkg::KEY_W-1:0] pool_key     [POOL_SIZE];

  koct_pkg::res_t pending_results [$];
  request_t       directed_plan [$];
  int             mismatches;
  int             tx_pct;
  int             rx_pct;
  int             random_done;
  bit             hold_request;
  longint         cycle_count;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Apply one request to the local table; returns 1 where a result is due.
  function automatic bit table_update(input logic [koct_pkg::CMD_W-1:0] cmd,
                                      input logic [koct_pkg::CH_W-1:0] ch,
                                      input logic [koct_pkg::KEY_W-1:0] key,
                                      input logic [koct_pkg::IDX_W-1:0] idx,
                                      output koct_pkg::res_t r);
    int hit;
    hit = -1;
    r = '0;
    case (cmd)
      koct_pkg::CMD_ADD: begin
        for (int i = 0; i < tbl_fill; i++) begin
          if (hit < 0 && tbl_channel[i] == ch && tbl_key[i] == key) hit = i;
        end
        r.entry_channel = ch;
        r.entry_key     = key;
        if (hit >= 0) begin
          if (tbl_count[hit] != '1) tbl_count[hit] = tbl_count[hit] + 1'b1;
          r.status      = koct_pkg::ST_COUNTED;
          r.entry_count = tbl_count[hit];
        end else if (tbl_fill >= TABLE_ENTRIES) begin
          r.status = koct_pkg::ST_FULL;
        end else begin
          tbl_channel[tbl_fill] = ch;
          tbl_key[tbl_fill]     = key;
          tbl_count[tbl_fill]   = 1;
          tbl_fill++;
          r.status      = koct_pkg::ST_INSERTED;
          r.entry_count = 1;
        end
        r.entries_used = koct_pkg::USED_W'(tbl_fill);
        return 1'b1;
      end
      koct_pkg::CMD_READ: begin
        if (int'(idx) < tbl_fill) begin
          r.status        = koct_pkg::ST_READ_OK;
          r.entry_channel = tbl_channel[idx];
          r.entry_key     = tbl_key[idx];
          r.entry_count   = tbl_count[idx];
        end else begin
          r.status = koct_pkg::ST_BAD_INDEX;
        end
        r.entries_used = koct_pkg::USED_W'(tbl_fill);
        return 1'b1;
      end
      koct_pkg::CMD_CLEAR: begin
        tbl_fill = 0;
        r.status = koct_pkg::ST_CLEARED;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic plan(input logic [koct_pkg::CMD_W-1:0] cmd,
                      input logic [koct_pkg::CH_W-1:0] ch,
                      input logic [koct_pkg::KEY_W-1:0] key,
                      input logic [koct_pkg::IDX_W-1:0] idx);
    request_t s;
    s.cmd   = cmd;
    s.ch    = ch;
    s.key   = key;
    s.idx   = idx;
    s.known = 1'b0;
    s.res   = '0;
    directed_plan.push_back(s);
  endtask

  task automatic plan_known(input logic [koct_pkg::CMD_W-1:0] cmd,
                            input logic [koct_pkg::CH_W-1:0] ch,
                            input logic [koct_pkg::KEY_W-1:0] key,
                            input logic [koct_pkg::IDX_W-1:0] idx,
                            input koct_pkg::status_t st,
                            input logic [koct_pkg::CH_W-1:0] rch,
                            input logic [koct_pkg::KEY_W-1:0] rkey,
                            input logic [koct_pkg::CNT_W-1:0] rcnt,
                            input logic [koct_pkg::USED_W-1:0] rused);
    request_t s;
    s.cmd               = cmd;
    s.ch                = ch;
    s.key               = key;
    s.idx               = idx;
    s.known             = 1'b1;
    s.res.status        = st;
    s.res.entry_channel = rch;
    s.res.entry_key     = rkey;
    s.res.entry_count   = rcnt;
    s.res.entries_used  = rused;
    directed_plan.push_back(s);
  endtask

  function automatic request_t make_add(input bit from_pool);
    request_t s;
    int slot;
    slot    = $urandom_range(POOL_SIZE - 1);
    s.cmd   = koct_pkg::CMD_ADD;
    s.idx   = koct_pkg::IDX_W'($urandom());
    s.known = 1'b0;
    s.res   = '0;
    if (from_pool) begin
      s.ch  = pool_channel[slot];
      s.key = pool_key[slot];
    end else begin
      s.ch  = koct_pkg::CH_W'($urandom());
      s.key = {$urandom(), $urandom()};
      pool_channel[slot] = s.ch;
      pool_key[slot]     = s.key;
    end
    return s;
  endfunction

  function automatic request_t make_other(input logic [koct_pkg::CMD_W-1:0] cmd,
                                          input logic [koct_pkg::IDX_W-1:0] idx);
    request_t s;
    s.cmd   = cmd;
    s.ch    = koct_pkg::CH_W'($urandom());
    s.key   = {$urandom(), $urandom()};
    s.idx   = idx;
    s.known = 1'b0;
    s.res   = '0;
    return s;
  endfunction

  // Offer one request, hold it until taken, then record what it should return.
  task automatic issue(input request_t s);
    int gap;
    koct_pkg::res_t predicted;
    gap = 0;
    while (tx_pct > 0 && $urandom_range(99) < tx_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= s.cmd;
    in_ch.channel    <= s.ch;
    in_ch.cell_key   <= s.key;
    in_ch.read_index <= s.idx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (table_update(s.cmd, s.ch, s.key, s.idx, predicted))
      pending_results.push_back(s.known ? s.res : predicted);
  endtask

  // Add fresh keys until the table is full, then push past the end.
  task automatic fill_table();
    while (tbl_fill < TABLE_ENTRIES) begin
      issue(make_add(1'b0));
      random_done++;
    end
    for (int k = 0; k < 4; k++) begin
      issue(make_add(1'b0));
      issue(make_add(1'b1));
      random_done += 2;
    end
    issue(make_other(koct_pkg::CMD_READ, koct_pkg::IDX_W'(TABLE_ENTRIES - 1)));
    issue(make_other(koct_pkg::CMD_READ, '0));
    random_done += 2;
  endtask

  // result side: check accepted results, stall at random or hold off on request
  initial begin : result_side
    koct_pkg::res_t want;
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", out_ch.status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", want.status, out_ch.status);
          compare_field("entry_channel", want.entry_channel, out_ch.entry_channel);
          compare_field("entry_key", want.entry_key, out_ch.entry_key);
          compare_field("entry_count", want.entry_count, out_ch.entry_count);
          compare_field("entries_used", want.entries_used, out_ch.entries_used);
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_pct);
      end
    end
  end

  initial begin : request_side
    int roll;
    bit hold_done;
    bit drain_done;
    bit fill_done;
    logic [koct_pkg::IDX_W-1:0] idx;

    in_ch.valid      = 1'b0;
    in_ch.cmd        = koct_pkg::CMD_ADD;
    in_ch.channel    = '0;
    in_ch.cell_key   = '0;
    in_ch.read_index = '0;
    rst_n            = 1'b0;
    tbl_fill         = 0;
    mismatches       = 0;
    random_done      = 0;
    hold_request     = 1'b0;
    hold_done        = 1'b0;
    drain_done       = 1'b0;
    fill_done        = 1'b0;
    tx_pct           = 33;
    rx_pct           = 75;
    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_channel[p] = koct_pkg::CH_W'($urandom());
      pool_key[p]     = {$urandom(), $urandom()};
    end

    plan_known(koct_pkg::CMD_READ, '0, '0, '0,
               koct_pkg::ST_BAD_INDEX, '0, '0, '0, 9'd0);
    plan_known(koct_pkg::CMD_ADD, '0, '0, '0,
               koct_pkg::ST_INSERTED, '0, '0, 32'd1, 9'd1);
    plan_known(koct_pkg::CMD_ADD, '1, '1, '1,
               koct_pkg::ST_INSERTED, '1, '1, 32'd1, 9'd2);
    plan_known(koct_pkg::CMD_ADD, '0, '0, '1,
               koct_pkg::ST_COUNTED, '0, '0, 32'd2, 9'd2);
    plan_known(koct_pkg::CMD_ADD, '1, '1, '0,
               koct_pkg::ST_COUNTED, '1, '1, 32'd2, 9'd2);
    // same channel or same key alone must not match
    plan(koct_pkg::CMD_ADD, '1, '0, '0);
    plan(koct_pkg::CMD_ADD, '0, '1, '0);
    plan(koct_pkg::CMD_READ, '1, '1, 8'd0);
    plan(koct_pkg::CMD_READ, '0, '0, 8'd3);
    plan_known(koct_pkg::CMD_READ, '0, '0, 8'd4,
               koct_pkg::ST_BAD_INDEX, '0, '0, '0, 9'd4);
    plan_known(koct_pkg::CMD_READ, '1, '1, '1,
               koct_pkg::ST_BAD_INDEX, '0, '0, '0, 9'd4);
    // unused code: taken, no result, table untouched
    plan(CMD_UNUSED, '1, '1, '1);
    plan(koct_pkg::CMD_ADD, 14'h2AAA, 64'h5555_5555_5555_5555, 8'hAA);
    plan(koct_pkg::CMD_ADD, 14'h1555, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55);
    plan(koct_pkg::CMD_READ, 14'h1555, '0, 8'd5);
    plan(koct_pkg::CMD_READ, '0, '0, 8'd1);
    plan_known(koct_pkg::CMD_CLEAR, '1, '1, '1,
               koct_pkg::ST_CLEARED, '0, '0, '0, 9'd0);
    plan_known(koct_pkg::CMD_READ, '0, '0, 8'd0,
               koct_pkg::ST_BAD_INDEX, '0, '0, '0, 9'd0);
    plan_known(koct_pkg::CMD_ADD, 14'h2AAA, 64'hAAAA_AAAA_AAAA_AAAA, '0,
               koct_pkg::ST_INSERTED, 14'h2AAA, 64'hAAAA_AAAA_AAAA_AAAA, 32'd1, 9'd1);
    plan(koct_pkg::CMD_READ, '0, '0, 8'd0);
    plan_known(koct_pkg::CMD_CLEAR, '0, '0, '0,
               koct_pkg::ST_CLEARED, '0, '0, '0, 9'd0);
    plan_known(koct_pkg::CMD_CLEAR, '0, '0, '0,
               koct_pkg::ST_CLEARED, '0, '0, '0, 9'd0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) issue(directed_plan[i]);

    while (random_done < RANDOM_ITEMS) begin
      if (random_done < RANDOM_ITEMS / 3) begin
        tx_pct = 33;
        rx_pct = 75;
      end else if (random_done < 2 * RANDOM_ITEMS / 3) begin
        tx_pct = 75;
        rx_pct = 33;
      end else begin
        tx_pct = 0;
        rx_pct = 0;
      end

      if (!hold_done && random_done >= 120) begin
        // stall the result side while requests keep coming
        hold_done    = 1'b1;
        hold_request = 1'b1;
      end
      if (!drain_done && random_done >= 300) begin
        drain_done = 1'b1;
        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end

      if (!fill_done && random_done >= 400) begin
        fill_done = 1'b1;
        fill_table();
      end else begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          // noise: ignored by the block, not counted
          issue(make_other(CMD_UNUSED, koct_pkg::IDX_W'($urandom())));
        end else begin
          if (roll < 5) begin
            issue(make_other(koct_pkg::CMD_CLEAR, koct_pkg::IDX_W'($urandom())));
          end else if (roll < 30) begin
            if (tbl_fill > 0 && $urandom_range(3) != 0)
              idx = koct_pkg::IDX_W'($urandom_range(tbl_fill - 1));
            else
              idx = koct_pkg::IDX_W'($urandom());
            issue(make_other(koct_pkg::CMD_READ, idx));
          end else begin
            issue(make_add($urandom_range(99) < 60));
          end
          random_done++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/koct_pkg.sv
sv/koct_in_if.sv
sv/koct_out_if.sv
sv/koct_ram.sv
sv/koct_ctrl.sv
sv/keyed_occurrence_count_table_top.sv
tb/testbench.sv
